/* rtl/btot_pkg.sv */
`default_nettype none
package btot_pkg;

  localparam int HALF_WIDTH = 15;
  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

/* rtl/btot_axis_cmp.sv */
`default_nettype none
module btot_axis_cmp #(
  parameter int DW = 16,
  parameter int RW = 16
) (
  input  wire logic signed [DW-1:0] d0,
  input  wire logic signed [DW-1:0] d1,
  input  wire logic signed [DW-1:0] d2,
  input  wire logic signed [RW-1:0] rad,
  output logic                      sep
);

  localparam int CW = ((DW > RW) ? DW : RW) + 1;

  logic signed [CW-1:0] x0, x1, x2, r, nr, lo, hi;

  always_comb begin
    x0 = {{(CW-DW){d0[DW-1]}}, d0};
    x1 = {{(CW-DW){d1[DW-1]}}, d1};
    x2 = {{(CW-DW){d2[DW-1]}}, d2};
    r  = {{(CW-RW){rad[RW-1]}}, rad};
    nr = -r;
    lo = x0;
    hi = x0;
    if (x1 < lo) lo = x1;
    if (x1 > hi) hi = x1;
    if (x2 < lo) lo = x2;
    if (x2 > hi) hi = x2;
    sep = (lo > r) || (hi < nr);
  end

endmodule
`default_nettype wire

/* rtl/box_triangle_overlap_test.sv */
`default_nettype none
// channel   | ports                               | transaction
// ----------+-------------------------------------+----------------------------------
// input     | in_valid in_ready in_center_* in_vert*_* | box center and triangle
// output    | out_valid out_ready out_overlaps    | one overlap flag per input
// config    | psel penable pwrite paddr pwdata prdata pready | half sizes at 0x0 0x4 0x8
//
// six register stages: vertex offsets, edges, products, normal and edge axes,
// normal projections, output register; one item per cycle while the pipeline advances
// the whole pipeline advances when the output register is empty or taken
// reset clears valid bits and the half-size registers
module box_triangle_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]     in_center_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_center_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_center_z,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert0_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert0_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert0_z,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert1_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert1_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert1_z,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert2_x,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert2_y,
  input  wire logic signed [COORD_WIDTH-1:0]     in_vert2_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_overlaps,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [btot_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [btot_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [btot_pkg::DATA_WIDTH-1:0]        prdata,
  output logic                                   pready
);

  localparam int W   = COORD_WIDTH;
  localparam int HW  = btot_pkg::HALF_WIDTH;
  localparam int PW  = W + 1;
  localparam int EW  = W + 2;
  localparam int NPW = 2 * EW;
  localparam int NW  = NPW + 1;
  localparam int EPW = PW + EW;
  localparam int DEW = EPW + 1;
  localparam int ERW = HW + EW - 1;
  localparam int RE  = ERW + 2;
  localparam int NDW = PW + NW;
  localparam int DNW = NDW + 2;
  localparam int NRW = HW + NW - 1;
  localparam int RN  = NRW + 3;

  logic [HW-1:0] half_r [3];
  logic          wr_en;
  btot_pkg::reg_idx_t widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = btot_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= '0;
      half_r[1] <= '0;
      half_r[2] <= '0;
    end else if (wr_en) begin
      unique case (widx)
        btot_pkg::REG_HALF_X: half_r[0] <= pwdata[HW-1:0];
        btot_pkg::REG_HALF_Y: half_r[1] <= pwdata[HW-1:0];
        btot_pkg::REG_HALF_Z: half_r[2] <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      btot_pkg::REG_HALF_X: prdata = {{(btot_pkg::DATA_WIDTH-HW){1'b0}}, half_r[0]};
      btot_pkg::REG_HALF_Y: prdata = {{(btot_pkg::DATA_WIDTH-HW){1'b0}}, half_r[1]};
      btot_pkg::REG_HALF_Z: prdata = {{(btot_pkg::DATA_WIDTH-HW){1'b0}}, half_r[2]};
      default:              prdata = '0;
    endcase
  end

  logic adv;
  logic out_valid_r, out_overlaps_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign adv          = !out_valid_r || out_ready;
  assign in_ready     = adv;
  assign out_valid    = out_valid_r;
  assign out_overlaps = out_overlaps_r;

  // stage 1: vertices relative to the centre
  logic signed [W-1:0]  cin [3];
  logic signed [W-1:0]  vin [3][3];
  logic signed [PW-1:0] p_nxt [3][3];
  logic signed [PW-1:0] p1_r [3][3];

  always_comb begin
    cin[0] = in_center_x; cin[1] = in_center_y; cin[2] = in_center_z;
    vin[0][0] = in_vert0_x; vin[0][1] = in_vert0_y; vin[0][2] = in_vert0_z;
    vin[1][0] = in_vert1_x; vin[1][1] = in_vert1_y; vin[1][2] = in_vert1_z;
    vin[2][0] = in_vert2_x; vin[2][1] = in_vert2_y; vin[2][2] = in_vert2_z;
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[v][c] = {vin[v][c][W-1], vin[v][c]} - {cin[c][W-1], cin[c]};
      end
    end
  end

  // stage 2: edges
  logic signed [EW-1:0] e_nxt [3][3];
  logic signed [EW-1:0] e2_r [3][3];
  logic signed [PW-1:0] p2_r [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        e_nxt[i][c] = {p1_r[(i == 2) ? 0 : i + 1][c][PW-1], p1_r[(i == 2) ? 0 : i + 1][c]}
                    - {p1_r[i][c][PW-1], p1_r[i][c]};
      end
    end
  end

  // stage 3: products; coordinate axes tested on stage 2 data
  logic sepu [3];
  logic sep3_r;

  for (genvar k = 0; k < 3; k++) begin : g_unit
    btot_axis_cmp #(.DW(PW), .RW(HW + 1)) u_cmp (
      .d0(p2_r[0][k]), .d1(p2_r[1][k]), .d2(p2_r[2][k]),
      .rad($signed({1'b0, half_r[k]})), .sep(sepu[k])
    );
  end

  logic signed [NPW-1:0] np_nxt [6];
  logic signed [NPW-1:0] np3_r  [6];
  logic signed [EPW-1:0] eu_nxt [3][3][3];
  logic signed [EPW-1:0] ew_nxt [3][3][3];
  logic signed [EPW-1:0] eu3_r  [3][3][3];
  logic signed [EPW-1:0] ew3_r  [3][3][3];
  logic [ERW-1:0]        ra_nxt [3][3];
  logic [ERW-1:0]        rb_nxt [3][3];
  logic [ERW-1:0]        ra3_r  [3][3];
  logic [ERW-1:0]        rb3_r  [3][3];
  logic signed [PW-1:0]  p3_r   [3][3];
  logic signed [EW-1:0]  eneg   [3][3];
  logic [EW-2:0]         eabs   [3][3];

  always_comb begin
    np_nxt[0] = e2_r[0][1] * e2_r[1][2];
    np_nxt[1] = e2_r[1][1] * e2_r[0][2];
    np_nxt[2] = e2_r[0][2] * e2_r[1][0];
    np_nxt[3] = e2_r[0][0] * e2_r[1][2];
    np_nxt[4] = e2_r[0][0] * e2_r[1][1];
    np_nxt[5] = e2_r[0][1] * e2_r[1][0];
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        eneg[i][c] = e2_r[i][c][EW-1] ? -e2_r[i][c] : e2_r[i][c];
        eabs[i][c] = eneg[i][c][EW-2:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ra_nxt[k][i] = half_r[(k == 2) ? 0 : k + 1] * eabs[i][(k == 0) ? 2 : k - 1];
        rb_nxt[k][i] = half_r[(k == 0) ? 2 : k - 1] * eabs[i][(k == 2) ? 0 : k + 1];
        for (int v = 0; v < 3; v++) begin
          eu_nxt[k][i][v] = p2_r[v][(k == 0) ? 2 : k - 1] * e2_r[i][(k == 2) ? 0 : k + 1];
          ew_nxt[k][i][v] = p2_r[v][(k == 2) ? 0 : k + 1] * e2_r[i][(k == 0) ? 2 : k - 1];
        end
      end
    end
  end

  // stage 4: normal components, edge-axis tests
  logic signed [DEW-1:0] edot [3][3][3];
  logic signed [RE-1:0]  erad [3][3];
  logic                  sepe [3][3];
  logic signed [NW-1:0]  n_nxt [3];
  logic signed [NW-1:0]  n4_r  [3];
  logic signed [PW-1:0]  p4_r  [3][3];
  logic                  sep4_r;
  logic                  sepe_any;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_nxt[c] = {np3_r[2*c][NPW-1], np3_r[2*c]} - {np3_r[2*c+1][NPW-1], np3_r[2*c+1]};
    end
    sepe_any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        erad[k][i] = $signed({2'b00, ra3_r[k][i]} + {2'b00, rb3_r[k][i]});
        sepe_any = sepe_any | sepe[k][i];
        for (int v = 0; v < 3; v++) begin
          edot[k][i][v] = {eu3_r[k][i][v][EPW-1], eu3_r[k][i][v]}
                        - {ew3_r[k][i][v][EPW-1], ew3_r[k][i][v]};
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ek
    for (genvar i = 0; i < 3; i++) begin : g_ei
      btot_axis_cmp #(.DW(DEW), .RW(RE)) u_cmp (
        .d0(edot[k][i][0]), .d1(edot[k][i][1]), .d2(edot[k][i][2]),
        .rad(erad[k][i]), .sep(sepe[k][i])
      );
    end
  end

  // stage 5: normal projections
  logic signed [NDW-1:0] nd_nxt [3][3];
  logic signed [NDW-1:0] nd5_r  [3][3];
  logic [NRW-1:0]        nr_nxt [3];
  logic [NRW-1:0]        nr5_r  [3];
  logic signed [NW-1:0]  nneg   [3];
  logic                  sep5_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nneg[c]   = n4_r[c][NW-1] ? -n4_r[c] : n4_r[c];
      nr_nxt[c] = half_r[c] * nneg[c][NW-2:0];
      for (int v = 0; v < 3; v++) begin
        nd_nxt[v][c] = p4_r[v][c] * n4_r[c];
      end
    end
  end

  // stage 6: normal axis test and result
  logic signed [DNW-1:0] ndot [3];
  logic signed [RN-1:0]  nrad;
  logic                  sepn;

  always_comb begin
    nrad = $signed({3'b000, nr5_r[0]} + {3'b000, nr5_r[1]} + {3'b000, nr5_r[2]});
    for (int v = 0; v < 3; v++) begin
      ndot[v] = {{2{nd5_r[v][0][NDW-1]}}, nd5_r[v][0]}
              + {{2{nd5_r[v][1][NDW-1]}}, nd5_r[v][1]}
              + {{2{nd5_r[v][2][NDW-1]}}, nd5_r[v][2]};
    end
  end

  btot_axis_cmp #(.DW(DNW), .RW(RN)) u_ncmp (
    .d0(ndot[0]), .d1(ndot[1]), .d2(ndot[2]), .rad(nrad), .sep(sepn)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= p_nxt;
      p2_r   <= p1_r;
      e2_r   <= e_nxt;
      p3_r   <= p2_r;
      np3_r  <= np_nxt;
      eu3_r  <= eu_nxt;
      ew3_r  <= ew_nxt;
      ra3_r  <= ra_nxt;
      rb3_r  <= rb_nxt;
      sep3_r <= sepu[0] | sepu[1] | sepu[2];
      p4_r   <= p3_r;
      n4_r   <= n_nxt;
      sep4_r <= sep3_r | sepe_any;
      nd5_r  <= nd_nxt;
      nr5_r  <= nr_nxt;
      sep5_r <= sep4_r;
      out_overlaps_r <= !(sep5_r | sepn);
    end
  end

endmodule
`default_nettype wire

/* rtl/btot_checker.sv */
`default_nettype none
module btot_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_overlaps,
  input wire logic pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_overlaps))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("config port not ready");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction dropped before accept");

endmodule

bind box_triangle_overlap_test btot_checker u_btot_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_overlaps(out_overlaps),
  .pready(pready)
);
`default_nettype wire
